// ===== rtl/lcf_pkg.sv =====
// lcf_pkg: shared types and codes for the link connection manager.
// Beat structs for both channels, config struct, event and register codes.
// No dependencies.
package lcf_pkg;

  localparam int CFG_IDX_W = 4;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONNECT_TIMEOUT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISCONNECT_TIMEOUT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_TIMEOUT  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES        = 4'd3;

  // event codes
  localparam logic [3:0] FUNC_TICK       = 4'd0;
  localparam logic [3:0] FUNC_CONNECT    = 4'd1;
  localparam logic [3:0] FUNC_ACCEPT     = 4'd2;
  localparam logic [3:0] FUNC_DISCONNECT = 4'd3;
  localparam logic [3:0] FUNC_DISC_ACK   = 4'd4;
  localparam logic [3:0] FUNC_REMOTE     = 4'd5;
  localparam logic [3:0] FUNC_FORCE      = 4'd6;
  localparam logic [3:0] FUNC_ACTIVITY   = 4'd7;
  localparam logic [3:0] FUNC_RESET      = 4'd8;

  // link state codes as seen on the result
  localparam logic [1:0] LS_DISCONNECTED  = 2'd0;
  localparam logic [1:0] LS_CONNECTING    = 2'd1;
  localparam logic [1:0] LS_CONNECTED     = 2'd2;
  localparam logic [1:0] LS_DISCONNECTING = 2'd3;

  // tick actions
  localparam logic [1:0] ACT_NONE      = 2'd0;
  localparam logic [1:0] ACT_RETRY     = 2'd1;
  localparam logic [1:0] ACT_TIMED_OUT = 2'd2;
  localparam logic [1:0] ACT_COMPLETE  = 2'd3;

  // disconnect reasons
  localparam logic [2:0] RSN_NONE        = 3'd0;
  localparam logic [2:0] RSN_LOCAL       = 3'd1;
  localparam logic [2:0] RSN_REMOTE      = 3'd2;
  localparam logic [2:0] RSN_TIMEOUT     = 3'd3;
  localparam logic [2:0] RSN_MAX_RETRIES = 3'd4;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] peer_user_id;
    logic [2:0]  force_reason;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  tick_action;
    logic [1:0]  link_state;
    logic [31:0] user_id_out;
    logic        user_id_valid;
    logic [2:0]  last_reason;
    logic        connected_event;
    logic        disconnected_event;
    logic        connect_failed_event;
    logic        state_changed;
  } out_item_t;

  typedef struct packed {
    logic [31:0] connect_timeout;
    logic [31:0] disconnect_timeout;
    logic [31:0] heartbeat_timeout;
    logic [7:0]  max_connect_retries;
  } cfg_regs_t;

endpackage

// ===== rtl/lcf_cfg.sv =====
// lcf_cfg: configuration register file of the link connection manager.
// Depends on lcf_pkg (cfg_regs_t, register indexes).
module lcf_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output lcf_pkg::cfg_regs_t            regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.connect_timeout     <= 32'd100;
      regs.disconnect_timeout  <= 32'd100;
      regs.heartbeat_timeout   <= 32'd1000;
      regs.max_connect_retries <= 8'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        lcf_pkg::REG_CONNECT_TIMEOUT:    regs.connect_timeout     <= cfg_data;
        lcf_pkg::REG_DISCONNECT_TIMEOUT: regs.disconnect_timeout  <= cfg_data;
        lcf_pkg::REG_HEARTBEAT_TIMEOUT:  regs.heartbeat_timeout   <= cfg_data;
        lcf_pkg::REG_MAX_RETRIES:        regs.max_connect_retries <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/lcf_in_stage.sv =====
// lcf_in_stage: input register in front of the state update.
// Depends on lcf_pkg (in_item_t).
module lcf_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lcf_pkg::in_item_t in_data,
  input  logic              take,      // core consumes the held beat
  output logic              held_valid,
  output lcf_pkg::in_item_t held_item
);

  // room when empty or the held beat leaves this cycle
  assign in_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      held_item <= in_data;
    end
  end

endmodule

// ===== rtl/lcf_core.sv =====
// lcf_core: connection state, timers and result register.
// Depends on lcf_pkg (item structs, codes, cfg_regs_t).
module lcf_core #(
  parameter int TIMER_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  lcf_pkg::cfg_regs_t regs,
  input  logic               item_valid,
  input  lcf_pkg::in_item_t  item,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output lcf_pkg::out_item_t out_data
);

  localparam int CMP_W = (TIMER_BITS > 32) ? TIMER_BITS : 32;

  typedef enum logic [1:0] {
    ST_DISC     = 2'd0,
    ST_CONNING  = 2'd1,
    ST_CONN     = 2'd2,
    ST_DISCING  = 2'd3
  } state_t;

  state_t                 st, st_next;
  logic [TIMER_BITS-1:0]  state_ticks, state_ticks_next;
  logic [TIMER_BITS-1:0]  idle_ticks, idle_ticks_next;
  logic [TIMER_BITS-1:0]  st_inc, idl_inc;
  logic [7:0]             retry_count, retry_count_next;
  logic [31:0]            held_user_id, held_user_id_next;
  logic                   held_user_valid, held_user_valid_next;
  logic [2:0]             reason, reason_next;
  lcf_pkg::out_item_t     res;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic reached(input logic [TIMER_BITS-1:0] t, input logic [31:0] lim);
    return CMP_W'(t) >= CMP_W'(lim);
  endfunction

  assign take = item_valid && (!out_valid || !out_stall);

  always_comb begin
    st_next              = st;
    state_ticks_next     = state_ticks;
    idle_ticks_next      = idle_ticks;
    retry_count_next     = retry_count;
    held_user_id_next    = held_user_id;
    held_user_valid_next = held_user_valid;
    reason_next          = reason;
    st_inc               = sat_inc(state_ticks);
    idl_inc              = sat_inc(idle_ticks);
    res                  = '0;
    res.status           = lcf_pkg::STATUS_OK;
    res.tick_action      = lcf_pkg::ACT_NONE;

    case (item.func)
      lcf_pkg::FUNC_TICK: begin
        state_ticks_next = st_inc;
        idle_ticks_next  = idl_inc;
        case (st)
          ST_CONNING: begin
            if (reached(st_inc, regs.connect_timeout)) begin
              if (retry_count >= regs.max_connect_retries) begin
                reason_next              = lcf_pkg::RSN_MAX_RETRIES;
                st_next                  = ST_DISC;
                res.connect_failed_event = 1'b1;
                res.disconnected_event   = 1'b1;
                res.tick_action          = lcf_pkg::ACT_TIMED_OUT;
              end else begin
                retry_count_next = retry_count + 8'd1;
                state_ticks_next = '0;
                res.tick_action  = lcf_pkg::ACT_RETRY;
              end
            end
          end
          ST_CONN: begin
            if (reached(idl_inc, regs.heartbeat_timeout)) begin
              reason_next            = lcf_pkg::RSN_TIMEOUT;
              st_next                = ST_DISC;
              res.disconnected_event = 1'b1;
              res.tick_action        = lcf_pkg::ACT_TIMED_OUT;
            end
          end
          ST_DISCING: begin
            if (reached(st_inc, regs.disconnect_timeout)) begin
              reason_next            = lcf_pkg::RSN_LOCAL;
              st_next                = ST_DISC;
              res.disconnected_event = 1'b1;
              res.tick_action        = lcf_pkg::ACT_COMPLETE;
            end
          end
          default: ;
        endcase
      end
      lcf_pkg::FUNC_CONNECT: begin
        if (st != ST_DISC) begin
          res.status = lcf_pkg::STATUS_INVALID;
        end else begin
          retry_count_next     = '0;
          held_user_valid_next = 1'b0;
          reason_next          = lcf_pkg::RSN_NONE;
          st_next              = ST_CONNING;
        end
      end
      lcf_pkg::FUNC_ACCEPT: begin
        if (st != ST_CONNING) begin
          res.status = lcf_pkg::STATUS_INVALID;
        end else begin
          held_user_id_next    = item.peer_user_id;
          held_user_valid_next = 1'b1;
          st_next              = ST_CONN;
          res.connected_event  = 1'b1;
        end
      end
      lcf_pkg::FUNC_DISCONNECT: begin
        if (st != ST_CONN) begin
          res.status = lcf_pkg::STATUS_INVALID;
        end else begin
          st_next = ST_DISCING;
        end
      end
      lcf_pkg::FUNC_DISC_ACK: begin
        if (st != ST_DISCING) begin
          res.status = lcf_pkg::STATUS_INVALID;
        end else begin
          reason_next            = lcf_pkg::RSN_LOCAL;
          st_next                = ST_DISC;
          res.disconnected_event = 1'b1;
        end
      end
      lcf_pkg::FUNC_REMOTE: begin
        if (st == ST_DISC) begin
          res.status = lcf_pkg::STATUS_INVALID;
        end else begin
          reason_next            = lcf_pkg::RSN_REMOTE;
          st_next                = ST_DISC;
          res.disconnected_event = 1'b1;
        end
      end
      lcf_pkg::FUNC_FORCE: begin
        // ignored quietly when already down
        if (st != ST_DISC) begin
          reason_next            = item.force_reason;
          st_next                = ST_DISC;
          res.disconnected_event = 1'b1;
        end
      end
      lcf_pkg::FUNC_ACTIVITY: begin
        idle_ticks_next = '0;
      end
      lcf_pkg::FUNC_RESET: begin
        st_next              = ST_DISC;
        state_ticks_next     = '0;
        idle_ticks_next      = '0;
        retry_count_next     = '0;
        held_user_id_next    = '0;
        held_user_valid_next = 1'b0;
        reason_next          = lcf_pkg::RSN_NONE;
      end
      default: begin
        res.status = lcf_pkg::STATUS_INVALID;
      end
    endcase

    // any state change restarts both timers; going down drops the user id
    if (st_next != st) begin
      state_ticks_next = '0;
      idle_ticks_next  = '0;
      if (st_next == ST_DISC) begin
        held_user_valid_next = 1'b0;
      end
    end

    res.link_state    = 2'(st_next);
    res.user_id_out   = held_user_valid_next ? held_user_id_next : 32'd0;
    res.user_id_valid = held_user_valid_next;
    res.last_reason   = reason_next;
    res.state_changed = (st_next != st);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= ST_DISC;
      state_ticks     <= '0;
      idle_ticks      <= '0;
      retry_count     <= '0;
      held_user_id    <= '0;
      held_user_valid <= 1'b0;
      reason          <= lcf_pkg::RSN_NONE;
      out_valid       <= 1'b0;
    end else if (take) begin
      st              <= st_next;
      state_ticks     <= state_ticks_next;
      idle_ticks      <= idle_ticks_next;
      retry_count     <= retry_count_next;
      held_user_id    <= held_user_id_next;
      held_user_valid <= held_user_valid_next;
      reason          <= reason_next;
      out_valid       <= 1'b1;
    end else if (!out_stall) begin
      out_valid       <= 1'b0;
    end
    if (take) begin
      out_data <= res;
    end
  end

endmodule

// ===== rtl/link_connection_fsm_top.sv =====
// link_connection_fsm_top: four-state link connection manager.
// Input beat to result beat passes the input register, then the result register.
// Throughput: one event per cycle without out_stall; state update is one compare pass.
// Reset (rst, synchronous): link Disconnected, timers/retries/user id/reason cleared,
// config back to connect 100, disconnect 100, heartbeat 1000, retries 3; no beat held.
module link_connection_fsm_top #(
  parameter int TIMER_BITS = 32    // width of the saturating tick timers, 8..64
) (
  input  logic                          clk,
  input  logic                          rst,
  // event channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lcf_pkg::in_item_t             in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output lcf_pkg::out_item_t            out_data,
  // config write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  lcf_pkg::cfg_regs_t regs;
  lcf_pkg::in_item_t  held_item;
  logic               held_valid;
  logic               take;

  // Config registers; ready is always high, and writes are registered.
  lcf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // Input register: holds one event beat; stalls only when the result
  // register is full and its beat is not being taken.
  lcf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // State update and result register. The state advances at the same edge
  // that loads the result, so back-to-back events see each other's effect.
  lcf_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .item_valid (held_valid),
    .item       (held_item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/lcf_checker.sv =====
// lcf_checker: port-level assertions for link_connection_fsm_top, plus its bind.
// Depends on lcf_pkg (out_item_t, codes).
module lcf_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input lcf_pkg::out_item_t out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // no user id is ever reported while disconnected
  a_disc_no_user: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.link_state == lcf_pkg::LS_DISCONNECTED |-> !out_data.user_id_valid)
    else $error("user id held while disconnected");

  // connect completes into Connected with a user id
  a_connected: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.connected_event |->
      out_data.link_state == lcf_pkg::LS_CONNECTED && out_data.state_changed &&
      out_data.user_id_valid)
    else $error("connected event without connected state");

  // retry exhaustion is a timed-out drop with the max-retries reason
  a_conn_failed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.connect_failed_event |->
      out_data.disconnected_event && out_data.tick_action == lcf_pkg::ACT_TIMED_OUT &&
      out_data.last_reason == lcf_pkg::RSN_MAX_RETRIES &&
      out_data.link_state == lcf_pkg::LS_DISCONNECTED)
    else $error("connect failure reported inconsistently");

  // user id reads zero when none is held
  a_uid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.user_id_valid |-> out_data.user_id_out == 32'd0)
    else $error("stale user id on result");

endmodule

bind link_connection_fsm_top lcf_checker u_lcf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/link_connection_fsm_checker.sv =====
// link_connection_fsm_checker: result predictor and in-order comparator for the link manager.
// Watches the event, result and config channels; depends on lcf_pkg only.
`timescale 1ns / 1ps
module link_connection_fsm_checker
  import lcf_pkg::*;
#(
  parameter int TIMER_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   pending,
  output int                   errors,
  output int                   checked,
  output int                   expiries
);

  localparam logic [63:0] TICK_CAP = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - TIMER_BITS);

  cfg_regs_t   regs;
  logic [1:0]  link_st;
  logic [63:0] st_ticks;
  logic [63:0] quiet_ticks;
  logic [7:0]  retries;
  logic [31:0] peer_id;
  logic        peer_held;
  logic [2:0]  reason;
  out_item_t   due_results[$];
  int          mism = 0;

  assign errors = mism;

  function automatic logic [63:0] bump(input logic [63:0] v);
    return (v >= TICK_CAP) ? TICK_CAP : v + 64'd1;
  endfunction

  // a real state change restarts both timers; dropping to Disconnected forgets the user
  function automatic void go_state(input logic [1:0] nxt);
    if (link_st != nxt) begin
      link_st     = nxt;
      st_ticks    = '0;
      quiet_ticks = '0;
      if (nxt == LS_DISCONNECTED) peer_held = 1'b0;
    end
  endfunction

  function automatic void clear_link();
    link_st     = LS_DISCONNECTED;
    st_ticks    = '0;
    quiet_ticks = '0;
    retries     = '0;
    peer_id     = '0;
    peer_held   = 1'b0;
    reason      = RSN_NONE;
  endfunction

  function automatic out_item_t next_link_result(input in_item_t ev);
    out_item_t  r;
    logic [1:0] was;
    was           = link_st;
    r             = '0;
    r.status      = STATUS_OK;
    r.tick_action = ACT_NONE;
    case (ev.func)
      FUNC_TICK: begin
        st_ticks    = bump(st_ticks);
        quiet_ticks = bump(quiet_ticks);
        case (link_st)
          LS_CONNECTING: begin
            if (st_ticks >= regs.connect_timeout) begin
              if (retries >= regs.max_connect_retries) begin
                reason = RSN_MAX_RETRIES;
                go_state(LS_DISCONNECTED);
                r.connect_failed_event = 1'b1;
                r.disconnected_event   = 1'b1;
                r.tick_action          = ACT_TIMED_OUT;
              end else begin
                retries       = retries + 8'd1;
                st_ticks      = '0;
                r.tick_action = ACT_RETRY;
              end
            end
          end
          LS_CONNECTED: begin
            if (quiet_ticks >= regs.heartbeat_timeout) begin
              reason = RSN_TIMEOUT;
              go_state(LS_DISCONNECTED);
              r.disconnected_event = 1'b1;
              r.tick_action        = ACT_TIMED_OUT;
            end
          end
          LS_DISCONNECTING: begin
            if (st_ticks >= regs.disconnect_timeout) begin
              reason = RSN_LOCAL;
              go_state(LS_DISCONNECTED);
              r.disconnected_event = 1'b1;
              r.tick_action        = ACT_COMPLETE;
            end
          end
          default: ;
        endcase
      end
      FUNC_CONNECT: begin
        if (link_st != LS_DISCONNECTED) begin
          r.status = STATUS_INVALID;
        end else begin
          retries   = '0;
          peer_held = 1'b0;
          reason    = RSN_NONE;
          go_state(LS_CONNECTING);
        end
      end
      FUNC_ACCEPT: begin
        if (link_st != LS_CONNECTING) begin
          r.status = STATUS_INVALID;
        end else begin
          peer_id   = ev.peer_user_id;
          peer_held = 1'b1;
          go_state(LS_CONNECTED);
          r.connected_event = 1'b1;
        end
      end
      FUNC_DISCONNECT: begin
        if (link_st != LS_CONNECTED) r.status = STATUS_INVALID;
        else go_state(LS_DISCONNECTING);
      end
      FUNC_DISC_ACK: begin
        if (link_st != LS_DISCONNECTING) begin
          r.status = STATUS_INVALID;
        end else begin
          reason = RSN_LOCAL;
          go_state(LS_DISCONNECTED);
          r.disconnected_event = 1'b1;
        end
      end
      FUNC_REMOTE: begin
        if (link_st == LS_DISCONNECTED) begin
          r.status = STATUS_INVALID;
        end else begin
          reason = RSN_REMOTE;
          go_state(LS_DISCONNECTED);
          r.disconnected_event = 1'b1;
        end
      end
      FUNC_FORCE: begin
        // silently ignored when already down; a zero reason is stored as is
        if (link_st != LS_DISCONNECTED) begin
          reason = ev.force_reason;
          go_state(LS_DISCONNECTED);
          r.disconnected_event = 1'b1;
        end
      end
      FUNC_ACTIVITY: quiet_ticks = '0;
      FUNC_RESET:    clear_link();
      default:       r.status = STATUS_INVALID;
    endcase
    r.link_state    = link_st;
    r.user_id_out   = peer_held ? peer_id : '0;
    r.user_id_valid = peer_held;
    r.last_reason   = reason;
    r.state_changed = (link_st != was);
    return r;
  endfunction

  task automatic flag_error(input string msg);
    mism++;
    if (mism <= 10) $display("[%0t] mismatch at result %0d: %s", $time, checked, msg);
  endtask

  task automatic cmp_field(input string fld, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) flag_error($sformatf("%s expected %0h, got %0h", fld, want, got));
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    logic      took_in;
    logic      took_out;
    took_in  = in_valid && !in_stall;
    took_out = out_valid && !out_stall;
    if (rst) begin
      regs.connect_timeout     = 32'd100;
      regs.disconnect_timeout  = 32'd100;
      regs.heartbeat_timeout   = 32'd1000;
      regs.max_connect_retries = 8'd3;
      clear_link();
      due_results.delete();
      pending  <= 0;
      checked  <= 0;
      expiries <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CONNECT_TIMEOUT:    regs.connect_timeout     = cfg_data;
          REG_DISCONNECT_TIMEOUT: regs.disconnect_timeout  = cfg_data;
          REG_HEARTBEAT_TIMEOUT:  regs.heartbeat_timeout   = cfg_data;
          REG_MAX_RETRIES:        regs.max_connect_retries = cfg_data[7:0];
          default: ;
        endcase
      end
      // a result can never belong to the event taken on the same edge
      if (took_out) begin
        if (due_results.size() == 0) begin
          flag_error("result beat with nothing expected");
        end else begin
          want = due_results.pop_front();
          cmp_field("status", 32'(want.status), 32'(out_data.status));
          cmp_field("tick_action", 32'(want.tick_action), 32'(out_data.tick_action));
          cmp_field("link_state", 32'(want.link_state), 32'(out_data.link_state));
          cmp_field("user_id_out", want.user_id_out, out_data.user_id_out);
          cmp_field("user_id_valid", 32'(want.user_id_valid),
                    32'(out_data.user_id_valid));
          cmp_field("last_reason", 32'(want.last_reason), 32'(out_data.last_reason));
          cmp_field("connected_event", 32'(want.connected_event),
                    32'(out_data.connected_event));
          cmp_field("disconnected_event", 32'(want.disconnected_event),
                    32'(out_data.disconnected_event));
          cmp_field("connect_failed_event", 32'(want.connect_failed_event),
                    32'(out_data.connect_failed_event));
          cmp_field("state_changed", 32'(want.state_changed),
                    32'(out_data.state_changed));
        end
        checked <= checked + 1;
      end
      if (took_in) begin
        want = next_link_result(in_data);
        if (want.tick_action != ACT_NONE) expiries <= expiries + 1;
        due_results.push_back(want);
      end
      pending <= pending + int'(took_in) - int'(took_out);
    end
  end

endmodule

// ===== tb/link_connection_fsm_top_test.sv =====
// link_connection_fsm_top_test: stimulus and verdict for the link connection manager.
// Drives events, result back-pressure and register writes; needs lcf_pkg,
// link_connection_fsm_top and link_connection_fsm_checker.
`timescale 1ns / 1ps
module link_connection_fsm_top_test;
  import lcf_pkg::*;

  localparam int TIMER_BITS        = 32;
  localparam int LINK_LAT          = 2;         // input register + result register
  localparam int CYCLE_LIMIT       = 1_000_000;
  localparam int BEATS_PER_SETTING = 275;

  // codes outside the named sets, used on purpose
  localparam logic [2:0] RSN_FORCED_TOP  = 3'd7;
  localparam logic [3:0] FUNC_UNUSED_TOP = 4'hF;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  int pending;
  int errors;
  int checked;
  int expiries;
  int cyc          = 0;
  int beats_sent   = 0;
  int settings_run = 0;
  int stall_hold   = 0;

  // register values last written; only used to size tick runs near the timeouts
  logic [31:0] cur_ct      = 32'd100;
  logic [31:0] cur_dt      = 32'd100;
  logic [31:0] cur_hb      = 32'd1000;
  logic [7:0]  cur_retries = 8'd3;

  in_item_t plan_q[$];   // events planned but not yet sent
  bit       quiet = 1'b0; // sender runs back to back while set

  always #5 clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;

  link_connection_fsm_top #(.TIMER_BITS(TIMER_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  link_connection_fsm_checker #(.TIMER_BITS(TIMER_BITS)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .errors    (errors),
    .checked   (checked),
    .expiries  (expiries)
  );

  // Result back-pressure: held for random stretches. Mostly short stalls and short
  // open windows, now and then a long stall, and now and then a long open stretch.
  always @(posedge clk) begin : recv_pace
    int pick;
    if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        out_stall  <= 1'b0;
        stall_hold = $urandom_range(0, 7);
      end else if (pick < 88) begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(0, 2);
      end else if (pick < 96) begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(4, 24);
      end else begin
        out_stall  <= 1'b0;
        stall_hold = $urandom_range(40, 120);
      end
    end
  end

  function automatic in_item_t mk_beat(input logic [3:0] fn, input logic [31:0] id,
                                       input logic [2:0] why);
    in_item_t b;
    b.func         = fn;
    b.peer_user_id = id;
    b.force_reason = why;
    return b;
  endfunction

  // unused fields get random content too, so every payload bit toggles
  function automatic in_item_t rnd_beat(input logic [3:0] fn);
    return mk_beat(fn, $urandom, 3'($urandom_range(0, 7)));
  endfunction

  // A run of ticks sized around a timeout up to 8, so it sometimes falls just short,
  // sometimes just past; else at most 10. Rarely a long run, which reaches high retry
  // counts. Activity is sprinkled in to keep a connected link alive some of the time.
  task automatic plan_ticks(input logic [31:0] tmo);
    int n;
    n = (tmo > 8) ? 10 : int'(tmo) + 2;
    n = ($urandom_range(0, 59) == 0) ? $urandom_range(0, 300) : $urandom_range(0, n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) plan_q.push_back(rnd_beat(FUNC_ACTIVITY));
      plan_q.push_back(rnd_beat(FUNC_TICK));
    end
  endtask

  // One connection lifetime with random content, or a short burst of noise.
  task automatic plan_session();
    int pick;
    if ($urandom_range(0, 4) == 0) begin
      // noise: any code, the unused ones included
      repeat ($urandom_range(1, 4)) plan_q.push_back(rnd_beat(4'($urandom_range(0, 15))));
      return;
    end
    // usually make sure the link is down first; a drop while down is a no-op
    if ($urandom_range(0, 3) != 0) plan_q.push_back(rnd_beat(FUNC_FORCE));
    plan_q.push_back(rnd_beat(FUNC_CONNECT));
    plan_ticks(cur_ct);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      plan_q.push_back(rnd_beat(FUNC_REMOTE));  // peer gives up mid-handshake
      return;
    end
    if (pick == 1) begin
      plan_q.push_back(rnd_beat(FUNC_FORCE));
      return;
    end
    if (pick == 2) return;                      // left to retry or give up
    plan_q.push_back(rnd_beat(FUNC_ACCEPT));
    repeat ($urandom_range(0, 3)) plan_ticks(cur_hb);
    case ($urandom_range(0, 5))
      0, 1: begin
        plan_q.push_back(rnd_beat(FUNC_DISCONNECT));
        plan_ticks(cur_dt);
        if ($urandom_range(0, 1) == 1) plan_q.push_back(rnd_beat(FUNC_DISC_ACK));
      end
      2:       plan_q.push_back(rnd_beat(FUNC_REMOTE));
      3:       plan_q.push_back(rnd_beat(FUNC_FORCE));
      4:       plan_q.push_back(rnd_beat(FUNC_RESET));
      default: plan_ticks(cur_hb);              // heartbeat loss
    endcase
  endtask

  // Sends everything planned. Valid stays up across back-to-back beats; the payload
  // only changes after the beat is taken. The last beat is always followed by a gap,
  // so valid is down when this returns.
  task automatic send_planned();
    int gap;
    int pick;
    while (plan_q.size() > 0) begin
      in_valid <= 1'b1;
      in_data  <= plan_q.pop_front();
      do begin
        @(posedge clk);
      end while (in_stall);
      beats_sent++;
      if ($urandom_range(0, 19) == 0) quiet = ~quiet;
      pick = $urandom_range(0, 99);
      if (quiet || pick < 60) gap = 0;
      else if (pick < 90)     gap = $urandom_range(1, 3);
      else                    gap = $urandom_range(4, 30);
      if (plan_q.size() == 0 && gap == 0) gap = 1;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender until every expected result is back, then let the pipe settle.
  // The extra edge first makes sure the last beat is already counted as pending.
  task automatic wait_drained();
    @(posedge clk);
    while (pending > 0) @(posedge clk);
    repeat (LINK_LAT + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // only called with the block idle
  task automatic apply_setting(input logic [31:0] ct, input logic [31:0] dt,
                               input logic [31:0] hb, input logic [7:0] rt);
    write_reg(REG_CONNECT_TIMEOUT, ct);
    write_reg(REG_DISCONNECT_TIMEOUT, dt);
    write_reg(REG_HEARTBEAT_TIMEOUT, hb);
    write_reg(REG_MAX_RETRIES, {24'd0, rt});
    cur_ct      = ct;
    cur_dt      = dt;
    cur_hb      = hb;
    cur_retries = rt;
    settings_run++;
  endtask

  initial begin : stimulus
    int phase;
    int target;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Register reset values: every request that is illegal while down, a forced drop
    // while down (ignored, no error) and an unused code.
    plan_q.push_back(mk_beat(FUNC_ACCEPT, 32'h1234_5678, RSN_NONE));
    plan_q.push_back(mk_beat(FUNC_DISCONNECT, 32'h0, RSN_NONE));
    plan_q.push_back(mk_beat(FUNC_DISC_ACK, 32'h0, RSN_NONE));
    plan_q.push_back(mk_beat(FUNC_REMOTE, 32'h0, RSN_NONE));
    plan_q.push_back(mk_beat(FUNC_FORCE, 32'h0, RSN_FORCED_TOP));
    plan_q.push_back(mk_beat(FUNC_UNUSED_TOP, 32'hFFFF_FFFF, RSN_FORCED_TOP));
    send_planned();
    wait_drained();

    // Tiny timeouts so every tick outcome shows up in a few beats.
    apply_setting(32'd2, 32'd1, 32'd2, 8'd1);
    // one retry, then the retry limit gives up
    plan_q.push_back(mk_beat(FUNC_CONNECT, 32'h0, RSN_NONE));
    repeat (4) plan_q.push_back(mk_beat(FUNC_TICK, 32'h0, RSN_NONE));
    // largest user id; activity pushes the heartbeat loss out by one tick
    plan_q.push_back(mk_beat(FUNC_CONNECT, 32'h0, RSN_NONE));
    plan_q.push_back(mk_beat(FUNC_ACCEPT, 32'hFFFF_FFFF, RSN_NONE));
    plan_q.push_back(mk_beat(FUNC_TICK, 32'h0, RSN_NONE));
    plan_q.push_back(mk_beat(FUNC_ACTIVITY, 32'h0, RSN_NONE));
    plan_q.push_back(mk_beat(FUNC_TICK, 32'h0, RSN_NONE));
    plan_q.push_back(mk_beat(FUNC_TICK, 32'h0, RSN_NONE));
    // user id zero; local disconnect completes on the timer
    plan_q.push_back(mk_beat(FUNC_CONNECT, 32'h0, RSN_NONE));
    plan_q.push_back(mk_beat(FUNC_ACCEPT, 32'h0, RSN_NONE));
    plan_q.push_back(mk_beat(FUNC_DISCONNECT, 32'h0, RSN_NONE));
    plan_q.push_back(mk_beat(FUNC_TICK, 32'h0, RSN_NONE));
    // forced drop with a zero reason still reports a disconnect
    plan_q.push_back(mk_beat(FUNC_CONNECT, 32'h0, RSN_NONE));
    plan_q.push_back(mk_beat(FUNC_FORCE, 32'h0, RSN_NONE));
    // reset event while connected
    plan_q.push_back(mk_beat(FUNC_CONNECT, 32'h0, RSN_NONE));
    plan_q.push_back(mk_beat(FUNC_ACCEPT, 32'h5A5A_A5A5, RSN_NONE));
    plan_q.push_back(mk_beat(FUNC_RESET, 32'h0, RSN_NONE));
    send_planned();
    wait_drained();

    // Random part, one register setting per phase: defaults, smallest nonzero,
    // zero (fires on the first tick) with the most retries, the largest values,
    // then two random small settings where timeouts are frequent.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       apply_setting(32'd100, 32'd100, 32'd1000, 8'd3);
        1:       apply_setting(32'd1, 32'd1, 32'd1, 8'd0);
        2:       apply_setting(32'd0, 32'd0, 32'd0, 8'hFF);
        3:       apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        default: apply_setting($urandom_range(1, 6), $urandom_range(1, 6),
                               $urandom_range(1, 10), 8'($urandom_range(0, 3)));
      endcase
      // with a timeout on every tick, walk the retry count all the way to its limit
      if (cur_retries == 8'hFF && cur_ct <= 32'd1) begin
        plan_q.push_back(rnd_beat(FUNC_FORCE));
        plan_q.push_back(rnd_beat(FUNC_CONNECT));
        repeat (257) plan_q.push_back(rnd_beat(FUNC_TICK));
      end
      target = beats_sent + BEATS_PER_SETTING;
      while (beats_sent < target) begin
        repeat (3) plan_session();
        send_planned();
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
      wait_drained();
    end

    $display("Run summary: %0d events under %0d register settings, %0d results checked.",
             beats_sent, settings_run, checked);
    $display("Timer expiries seen: %0d (retries, give-ups, heartbeat losses, completions).",
             expiries);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    wait (cyc >= CYCLE_LIMIT);
    $display("cycle limit reached with %0d results outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lcf_pkg.sv
rtl/lcf_cfg.sv
rtl/lcf_in_stage.sv
rtl/lcf_core.sv
rtl/link_connection_fsm_top.sv
rtl/lcf_checker.sv
tb/link_connection_fsm_checker.sv
tb/link_connection_fsm_top_test.sv
